// ===== src/ofv_pkg.sv =====
// Package for the OTA frame validator: error codes, register indexes,
// reset values, shared structs and the bytewise CRC-16 update.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ofv_pkg;

  typedef enum logic [2:0] {
    ERR_OK        = 3'd0,
    ERR_SHORT     = 3'd1,
    ERR_HEADER    = 3'd2,
    ERR_COMMAND   = 3'd3,
    ERR_NOT_X16   = 3'd4,
    ERR_TRUNCATED = 3'd5,
    ERR_CRC       = 3'd6,
    ERR_PRIVATE   = 3'd7
  } err_code_t;

  localparam int CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] CFG_HEADER_FIRST     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_HEADER_SECOND    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_PASSTHROUGH_CODE = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_CRC_SEED         = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_ENCRYPT_MASK     = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_VERSION_SEL      = 3'd5;

  localparam logic [7:0]  RST_HEADER_FIRST     = 8'h55;
  localparam logic [7:0]  RST_HEADER_SECOND    = 8'hAA;
  localparam logic [7:0]  RST_PASSTHROUGH_CODE = 8'hFB;
  localparam logic [15:0] RST_CRC_SEED         = 16'hFFFF;
  localparam logic [7:0]  RST_ENCRYPT_MASK     = 8'h80;
  localparam logic [7:0]  RST_VERSION_SEL      = 8'h0F;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam int OFV_QUEUE_DEPTH = 2;
  localparam int OUT_TDATA_W     = 48;

  typedef struct packed {
    logic [7:0]  header_first;
    logic [7:0]  header_second;
    logic [7:0]  passthrough_code;
    logic [15:0] crc_seed;
    logic [7:0]  encrypt_mask;
    logic [7:0]  version_sel;
  } cfg_t;

  typedef struct packed {
    err_code_t   err;
    logic [7:0]  control_byte;
    logic        payload_nz;
    logic [31:0] private_hdr;
  } verdict_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== src/ofv_front.sv =====
// Front end of the OTA frame validator: per-byte frame state, CRC and
// header parsing; emits one verdict per final byte. Depends on ofv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ofv_front
  import ofv_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire cfg_t     cfg,
  input  wire logic     accept,
  input  wire logic [7:0] data_byte,
  input  wire logic     final_byte,
  output logic          push,
  output verdict_t      verdict
);

  logic [15:0] bc_r, bc_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [1:0]  hf_r, hf_nxt;
  logic        cmd_r, cmd_nxt;
  logic [7:0]  ctrl_r, ctrl_nxt;
  logic [15:0] pl_r, pl_nxt;
  logic [15:0] recent_r, recent_nxt;
  logic [31:0] pp_r, pp_nxt;
  logic [15:0] crc_base;
  logic        feed;
  err_code_t   err;

  always_comb begin
    crc_base   = (bc_r == 16'd0) ? cfg.crc_seed : crc_r;
    feed       = {1'b0, bc_r} < ({1'b0, pl_r} + 17'd6);
    crc_nxt    = feed ? crc16_byte(crc_base, data_byte) : crc_base;
    hf_nxt     = hf_r | {(bc_r == 16'd1) && (data_byte == cfg.header_second),
                         (bc_r == 16'd0) && (data_byte == cfg.header_first)};
    cmd_nxt    = (bc_r == 16'd3) ? (data_byte == cfg.passthrough_code) : cmd_r;
    ctrl_nxt   = (bc_r == 16'd2) ? data_byte : ctrl_r;
    pl_nxt     = pl_r;
    if (bc_r == 16'd4) pl_nxt = {data_byte, pl_r[7:0]};
    if (bc_r == 16'd5) pl_nxt = {pl_r[15:8], data_byte};
    pp_nxt     = (bc_r >= 16'd6 && bc_r <= 16'd9) ? {pp_r[23:0], data_byte} : pp_r;
    recent_nxt = {recent_r[7:0], data_byte};
    bc_nxt     = (bc_r == 16'hFFFF) ? bc_r : bc_r + 16'd1;

    priority if (bc_nxt < 16'd8) err = ERR_SHORT;
    else if (hf_nxt != 2'b11) err = ERR_HEADER;
    else if (!cmd_nxt) err = ERR_COMMAND;
    else if (pl_nxt[3:0] != 4'd0) err = ERR_NOT_X16;
    else if ({1'b0, bc_nxt} < ({1'b0, pl_nxt} + 17'd8)) err = ERR_TRUNCATED;
    else if (crc_nxt != recent_nxt) err = ERR_CRC;
    else if ((pl_nxt != 16'd0) &&
             ((pp_nxt[31:24] == 8'd0) ||
              (({1'b0, pp_nxt[15:0]} + 17'd4) > {1'b0, pl_nxt}))) err = ERR_PRIVATE;
    else err = ERR_OK;

    push                 = accept && final_byte;
    verdict.err          = err;
    verdict.control_byte = ctrl_nxt;
    verdict.payload_nz   = (pl_nxt != 16'd0);
    verdict.private_hdr  = pp_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bc_r     <= '0;
      crc_r    <= RST_CRC_SEED;
      hf_r     <= '0;
      cmd_r    <= 1'b0;
      ctrl_r   <= '0;
      pl_r     <= '0;
      recent_r <= '0;
      pp_r     <= '0;
    end else if (accept) begin
      if (final_byte) begin
        bc_r     <= '0;
        crc_r    <= cfg.crc_seed;
        hf_r     <= '0;
        cmd_r    <= 1'b0;
        ctrl_r   <= '0;
        pl_r     <= '0;
        recent_r <= '0;
        pp_r     <= '0;
      end else begin
        bc_r     <= bc_nxt;
        crc_r    <= crc_nxt;
        hf_r     <= hf_nxt;
        cmd_r    <= cmd_nxt;
        ctrl_r   <= ctrl_nxt;
        pl_r     <= pl_nxt;
        recent_r <= recent_nxt;
        pp_r     <= pp_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/ofv_fifo.sv =====
// Small verdict queue between front and back of the OTA frame validator.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none

module ofv_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             pop,
  output logic                  full,
  output logic                  not_empty,
  output logic [WIDTH-1:0]      rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wp_r, rp_r;
  logic [CW-1:0]    cnt_r;

  assign full      = (cnt_r == CW'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign rd_data   = mem_r[rp_r];

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= bump(wp_r);
      if (pop)  rp_r <= bump(rp_r);
      if (push && !pop) cnt_r <= cnt_r + CW'(1);
      else if (pop && !push) cnt_r <= cnt_r - CW'(1);
    end
  end

endmodule

`default_nettype wire

// ===== src/ofv_back.sv =====
// Back end of the OTA frame validator: applies verdicts to the held
// values and drives the registered result channel. Depends on ofv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ofv_back
  import ofv_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire cfg_t                   cfg,
  input  wire logic                   q_valid,
  input  wire verdict_t               q_data,
  output logic                        q_pop,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  logic                   valid_r;
  logic [OUT_TDATA_W-1:0] data_r, data_nxt;
  logic [8:0]             flags_r, flags_nxt;
  logic [31:0]            priv_r, priv_nxt;
  logic                   ok;

  assign q_pop      = q_valid && (!valid_r || out_tready);
  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

  always_comb begin
    ok        = (q_data.err == ERR_OK);
    flags_nxt = flags_r;
    priv_nxt  = priv_r;
    if (ok) begin
      flags_nxt = {|(q_data.control_byte & cfg.encrypt_mask),
                   q_data.control_byte & cfg.version_sel};
      if (q_data.payload_nz) priv_nxt = q_data.private_hdr;
    end
    data_nxt = {3'b000, priv_nxt[15:0], priv_nxt[23:16], priv_nxt[31:24],
                flags_nxt[7:0], flags_nxt[8], q_data.err, ok};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      flags_r <= '0;
      priv_r  <= '0;
    end else begin
      if (q_pop) begin
        valid_r <= 1'b1;
        flags_r <= flags_nxt;
        priv_r  <= priv_nxt;
      end else if (out_tready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) data_r <= data_nxt;
  end

endmodule

`default_nettype wire

// ===== src/ota_frame_validator.sv =====
// Top level of the OTA frame validator: configuration registers, front
// end, verdict queue and back end. Depends on ofv_pkg, ofv_front,
// ofv_fifo and ofv_back.
//
// Usage: frame bytes enter on the in_ stream one item per cycle while
// in_tready is high, in_tlast on the last byte of each frame. Non-final
// bytes give no result; each final byte gives one out_ stream verdict item.
// Path: the verdict goes from the front end into the queue, then into the
// output register, where it becomes visible.
// Throughput: one byte per cycle while in_tready is high, final bytes
// included, set by the bytewise CRC update in the front end.
// Stall: while out_tready is low, up to two verdicts wait in the queue
// plus one in the output register; then in_tready drops until space frees.
// Reset (rst_n low, synchronous): registers return to their defaults,
// frame state and held header values clear, the queue empties.
// Configuration: cfg_ready is always high; write only while idle.
`timescale 1ns / 1ps
`default_nettype none

module ota_frame_validator
  import ofv_pkg::*;
#(
  parameter int QUEUE_DEPTH = OFV_QUEUE_DEPTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [7:0]             in_tdata,   // [7:0] data_byte
  input  wire logic                   in_tlast,   // final_byte
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // [0] frame_ok, [3:1] error_code, [4] encrypted, [12:5] version,
  // [20:13] seq_number, [28:21] private_cmd, [44:29] content_length
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CfgIdxW-1:0]     cfg_index,
  input  wire logic [15:0]            cfg_data
);

  localparam int VW = $bits(verdict_t);

  cfg_t     cfg_r;
  logic     accept, push, q_full, q_valid, q_pop;
  verdict_t verdict, q_data;

  assign cfg_ready = 1'b1;
  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_first     <= RST_HEADER_FIRST;
      cfg_r.header_second    <= RST_HEADER_SECOND;
      cfg_r.passthrough_code <= RST_PASSTHROUGH_CODE;
      cfg_r.crc_seed         <= RST_CRC_SEED;
      cfg_r.encrypt_mask     <= RST_ENCRYPT_MASK;
      cfg_r.version_sel      <= RST_VERSION_SEL;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_HEADER_FIRST:     cfg_r.header_first     <= cfg_data[7:0];
        CFG_HEADER_SECOND:    cfg_r.header_second    <= cfg_data[7:0];
        CFG_PASSTHROUGH_CODE: cfg_r.passthrough_code <= cfg_data[7:0];
        CFG_CRC_SEED:         cfg_r.crc_seed         <= cfg_data;
        CFG_ENCRYPT_MASK:     cfg_r.encrypt_mask     <= cfg_data[7:0];
        CFG_VERSION_SEL:      cfg_r.version_sel      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  ofv_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .accept     (accept),
    .data_byte  (in_tdata),
    .final_byte (in_tlast),
    .push       (push),
    .verdict    (verdict)
  );

  ofv_fifo #(
    .WIDTH (VW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_data   (verdict),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .rd_data   (q_data)
  );

  ofv_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire
